FILE: sv/s2erle_pkg.sv
// Shared types and constants for the seven-to-eight-bit unpacker with run-length decoding.
package s2erle_pkg;

  localparam int ByteW = 8;
  localparam int CountW = 8;
  localparam int StatusW = 3;
  localparam int LengthW = 11;

  localparam logic [7:0] LowMask = 8'h7F;
  localparam logic [7:0] RunHdrBase = 8'd64;
  localparam logic [7:0] RunExtCode = 8'd31;
  localparam logic [7:0] BadHdrStart = 8'd60;
  localparam logic [7:0] Lit3Start = 8'd4;
  localparam logic [7:0] Lit4Start = 8'd12;
  localparam logic [7:0] Lit5Start = 8'd28;

  localparam logic [StatusW-1:0] StOk = 3'd0;
  localparam logic [StatusW-1:0] StBadHeader = 3'd1;
  localparam logic [StatusW-1:0] StShortLiteral = 3'd2;
  localparam logic [StatusW-1:0] StShortRun = 3'd3;
  localparam logic [StatusW-1:0] StLiteralOverflow = 3'd4;
  localparam logic [StatusW-1:0] StRunOverflow = 3'd5;

  typedef struct packed {
    logic [ByteW-1:0]   out_byte;
    logic [CountW-1:0]  repeat_count;
    logic               is_end;
    logic [StatusW-1:0] status;
    logic [LengthW-1:0] total_length;
  } result_t;

  typedef struct packed {
    logic [1:0] num;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

FILE: sv/s2erle_if.sv
// Stream interfaces for packed input bytes and decoded results.
interface s2erle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       is_last;

  modport source (output valid, output in_byte, output is_last, input ready);
  modport sink (input valid, input in_byte, input is_last, output ready);
endinterface

interface s2erle_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [7:0]  repeat_count;
  logic        is_end;
  logic [2:0]  status;
  logic [10:0] total_length;

  modport source (output valid, output out_byte, output repeat_count, output is_end,
                  output status, output total_length, input ready);
  modport sink (input valid, input out_byte, input repeat_count, input is_end,
                input status, input total_length, output ready);
endinterface

FILE: sv/s2erle_decoder.sv
// Per-byte header, literal and run decoder with message state and capacity register.
module s2erle_decoder #(
  parameter int CAPACITY_MAX = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [7:0]           in_byte,
  input  logic                 is_last,
  input  logic                 cfg_wr_en,
  input  logic [10:0]          cfg_wr_data,
  output s2erle_pkg::push_t    push
);

  typedef enum logic [2:0] {
    PhHeader,
    PhLiteral,
    PhRunExt,
    PhRunVal,
    PhDrop
  } phase_t;

  localparam logic [10:0] CapSat = (CAPACITY_MAX > 2047) ? 11'd2047 : 11'(CAPACITY_MAX);
  localparam logic [10:0] CapReset = (CAPACITY_MAX < 1024) ? 11'(CAPACITY_MAX) : 11'd1024;

  phase_t      phase, phase_next;
  logic [2:0]  literal_left, literal_left_next;
  logic [2:0]  literal_index, literal_index_next;
  logic [4:0]  high_bits, high_bits_next;
  logic        run_high, run_high_next;
  logic [7:0]  run_length, run_length_next;
  logic [10:0] decoded_count, decoded_count_next;
  logic        pending_overflow, pending_overflow_next;
  logic [2:0]  error_code, error_code_next;
  logic [10:0] capacity;

  logic [7:0]  run_value;
  logic [2:0]  lit_size;
  logic [7:0]  lit_base;
  logic        data_valid;
  s2erle_pkg::result_t data_res, end_res;

  always_comb begin
    phase_next = phase;
    literal_left_next = literal_left;
    literal_index_next = literal_index;
    high_bits_next = high_bits;
    run_high_next = run_high;
    run_length_next = run_length;
    decoded_count_next = decoded_count;
    pending_overflow_next = pending_overflow;
    error_code_next = error_code;
    data_valid = 1'b0;
    data_res = '0;
    end_res = '0;
    run_value = in_byte - s2erle_pkg::RunHdrBase;
    lit_size = 3'd5;
    lit_base = s2erle_pkg::Lit5Start;
    if (in_byte < s2erle_pkg::Lit3Start) begin
      lit_size = 3'd2;
      lit_base = 8'd0;
    end else if (in_byte < s2erle_pkg::Lit4Start) begin
      lit_size = 3'd3;
      lit_base = s2erle_pkg::Lit3Start;
    end else if (in_byte < s2erle_pkg::Lit5Start) begin
      lit_size = 3'd4;
      lit_base = s2erle_pkg::Lit4Start;
    end

    if (accept) begin
      case (phase)
        PhHeader: begin
          if (!is_last) begin
            if (in_byte < s2erle_pkg::RunHdrBase) begin
              if (in_byte >= s2erle_pkg::BadHdrStart) begin
                error_code_next = s2erle_pkg::StBadHeader;
                phase_next = PhDrop;
              end else begin
                literal_left_next = lit_size;
                literal_index_next = 3'd0;
                high_bits_next = 5'(in_byte - lit_base);
                pending_overflow_next =
                  ({1'b0, decoded_count} + 12'(lit_size)) > {1'b0, capacity};
                phase_next = PhLiteral;
              end
            end else begin
              run_high_next = run_value[0];
              run_length_next = {1'b0, run_value[7:1]};
              phase_next = ({1'b0, run_value[7:1]} == s2erle_pkg::RunExtCode) ?
                           PhRunExt : PhRunVal;
            end
          end
        end
        PhLiteral: begin
          data_valid = 1'b1;
          data_res.out_byte = {high_bits[literal_index], in_byte[6:0]};
          data_res.repeat_count = 8'd1;
          literal_index_next = literal_index + 3'd1;
          literal_left_next = literal_left - 3'd1;
          if (literal_left_next == 3'd0) begin
            if (pending_overflow) begin
              error_code_next = s2erle_pkg::StLiteralOverflow;
              phase_next = PhDrop;
            end else begin
              decoded_count_next = decoded_count + 11'(literal_index_next);
              phase_next = PhHeader;
            end
          end else if (is_last) begin
            error_code_next = s2erle_pkg::StShortLiteral;
            phase_next = PhDrop;
          end
        end
        PhRunExt: begin
          if (is_last) begin
            error_code_next = s2erle_pkg::StShortRun;
            phase_next = PhDrop;
          end else begin
            run_length_next = s2erle_pkg::RunExtCode + (in_byte & s2erle_pkg::LowMask);
            phase_next = PhRunVal;
          end
        end
        PhRunVal: begin
          if (({1'b0, decoded_count} + 12'(run_length)) > {1'b0, capacity}) begin
            error_code_next = s2erle_pkg::StRunOverflow;
            phase_next = PhDrop;
          end else begin
            data_valid = 1'b1;
            data_res.out_byte = {in_byte[7] ^ run_high, in_byte[6:0]};
            data_res.repeat_count = run_length;
            decoded_count_next = decoded_count + 11'(run_length);
            phase_next = PhHeader;
          end
        end
        default: begin
        end
      endcase

      if (is_last) begin
        end_res.is_end = 1'b1;
        end_res.status = error_code_next;
        end_res.total_length = decoded_count_next;
        phase_next = PhHeader;
        literal_left_next = '0;
        literal_index_next = '0;
        high_bits_next = '0;
        run_high_next = 1'b0;
        run_length_next = '0;
        decoded_count_next = '0;
        pending_overflow_next = 1'b0;
        error_code_next = s2erle_pkg::StOk;
      end
    end

    push.num = {1'b0, data_valid} + {1'b0, accept && is_last};
    push.first = data_valid ? data_res : end_res;
    push.second = end_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PhHeader;
      literal_left <= '0;
      literal_index <= '0;
      high_bits <= '0;
      run_high <= 1'b0;
      run_length <= '0;
      decoded_count <= '0;
      pending_overflow <= 1'b0;
      error_code <= s2erle_pkg::StOk;
      capacity <= CapReset;
    end else begin
      phase <= phase_next;
      literal_left <= literal_left_next;
      literal_index <= literal_index_next;
      high_bits <= high_bits_next;
      run_high <= run_high_next;
      run_length <= run_length_next;
      decoded_count <= decoded_count_next;
      pending_overflow <= pending_overflow_next;
      error_code <= error_code_next;
      if (cfg_wr_en) begin
        capacity <= (cfg_wr_data > CapSat) ? CapSat : cfg_wr_data;
      end
    end
  end

endmodule

FILE: sv/s2erle_result_fifo.sv
// Four-entry result queue that takes up to two results per cycle and hands out one.
module s2erle_result_fifo (
  input  logic                clk,
  input  logic                rst,
  input  s2erle_pkg::push_t   push,
  output logic                has_room,
  output logic                out_valid,
  input  logic                out_ready,
  output s2erle_pkg::result_t out_data
);

  s2erle_pkg::result_t entries [4];
  logic [1:0] head, tail;
  logic [2:0] count;
  logic       pop;

  assign has_room = count <= 3'd2;
  assign out_valid = count != 3'd0;
  assign out_data = entries[head];
  assign pop = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      count <= '0;
    end else begin
      if (push.num != 2'd0) begin
        entries[tail] <= push.first;
      end
      if (push.num == 2'd2) begin
        entries[tail + 2'd1] <= push.second;
      end
      tail <= tail + push.num;
      head <= head + {1'b0, pop};
      count <= count + {1'b0, push.num} - {2'b0, pop};
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= 3'd4)
    else $error("Result queue count exceeds its depth.");
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (push.num != 2'd0) |-> (count <= 3'd2))
    else $error("Results pushed while the queue lacks room for two.");
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (count == $past(count) + {1'b0, $past(push.num)} - {2'b0, $past(pop)}))
    else $error("Result queue count does not follow pushes and pops.");

endmodule

FILE: sv/seven_to_eight_rle_unpacker_top.sv
// Top level of the seven-to-eight-bit unpacker with run-length decoding.
//
//   Channel | Direction | Payload                                            | Width
//   in_ch   | sink      | in_byte, is_last                                   | 8+1
//   out_ch  | source    | out_byte, repeat_count, is_end, status, total_length | 8+8+1+3+11
//   cfg     | write     | cfg_wr_en, cfg_wr_data (output capacity)           | 1+11
//
// A byte is decoded in the cycle of its transfer and its results enter a four-entry queue.
// One byte is taken every cycle while the queue holds two results or fewer.
// A byte yields up to two results, so the output port of one result a cycle sets the rate.
// Reset is synchronous and returns the decoder to the header phase with an empty queue.
// A stalled output fills the queue and then holds the input off until room returns.
module seven_to_eight_rle_unpacker_top #(
  parameter int CAPACITY_MAX = 1024
) (
  input  logic         clk,
  input  logic         rst,
  s2erle_in_if.sink    in_ch,
  s2erle_out_if.source out_ch,
  input  logic         cfg_wr_en,
  input  logic [10:0]  cfg_wr_data
);

  s2erle_pkg::push_t   push;
  s2erle_pkg::result_t out_data;
  logic                has_room;
  logic                accept;

  assign in_ch.ready = has_room;
  assign accept = in_ch.valid && has_room;

  s2erle_decoder #(
    .CAPACITY_MAX(CAPACITY_MAX)
  ) u_decoder (
    .clk(clk),
    .rst(rst),
    .accept(accept),
    .in_byte(in_ch.in_byte),
    .is_last(in_ch.is_last),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .push(push)
  );

  s2erle_result_fifo u_fifo (
    .clk(clk),
    .rst(rst),
    .push(push),
    .has_room(has_room),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .out_data(out_data)
  );

  assign out_ch.out_byte = out_data.out_byte;
  assign out_ch.repeat_count = out_data.repeat_count;
  assign out_ch.is_end = out_data.is_end;
  assign out_ch.status = out_data.status;
  assign out_ch.total_length = out_data.total_length;

endmodule

FILE: bench/tb_seven_to_eight_rle_unpacker_top.sv
// Testbench for the seven-to-eight-bit unpacker, checked against a behavioral decoder.
`timescale 1ns / 1ps
module tb_seven_to_eight_rle_unpacker_top;

  localparam int CapMax = 1024;
  localparam int QuietLimit = 1000;
  localparam int PhaseItems = 85;
  localparam int NumPhases = 8;

  typedef enum logic [2:0] {PhHeader, PhLiteral, PhRunExt, PhRunVal, PhDrop} dec_phase_t;
  typedef enum logic [1:0] {RxOpen, RxCoin, RxSparse, RxPeriodic} rx_mode_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } in_item_t;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [10:0] cfg_wr_data;

  s2erle_in_if  in_ch();
  s2erle_out_if out_ch();

  seven_to_eight_rle_unpacker_top #(
    .CAPACITY_MAX(CapMax)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  in_item_t            pending_q[$];
  s2erle_pkg::result_t decoded_q[$];

  int       mismatches = 0;
  int       quiet_cycles = 0;
  int       queued_items = 0;
  logic     in_fire = 1'b0;
  logic     drv_busy = 1'b0;
  int       gap_left = 0;
  int       burst_left = 0;
  rx_mode_t rx_mode = RxOpen;
  int       rx_left = 0;
  int       rx_tick = 0;

  int         capacity;
  dec_phase_t ph;
  int         lit_left;
  int         lit_idx;
  logic [4:0] lit_high;
  logic       run_hi;
  int         run_len;
  int         dec_count;
  logic       lit_over;
  logic [2:0] err_st;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic clear_message();
    ph = PhHeader;
    lit_left = 0;
    lit_idx = 0;
    lit_high = '0;
    run_hi = 1'b0;
    run_len = 0;
    dec_count = 0;
    lit_over = 1'b0;
    err_st = s2erle_pkg::StOk;
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic last);
    s2erle_pkg::result_t r;
    logic [7:0]          val;
    logic [7:0]          rv;
    int                  size;
    int                  base;
    case (ph)
      PhHeader: begin
        if (!last) begin
          if (b < s2erle_pkg::RunHdrBase) begin
            if (b >= s2erle_pkg::BadHdrStart) begin
              err_st = s2erle_pkg::StBadHeader;
              ph = PhDrop;
            end else begin
              if (b < s2erle_pkg::Lit3Start) begin
                size = 2;
                base = 0;
              end else if (b < s2erle_pkg::Lit4Start) begin
                size = 3;
                base = int'(s2erle_pkg::Lit3Start);
              end else if (b < s2erle_pkg::Lit5Start) begin
                size = 4;
                base = int'(s2erle_pkg::Lit4Start);
              end else begin
                size = 5;
                base = int'(s2erle_pkg::Lit5Start);
              end
              lit_left = size;
              lit_idx = 0;
              lit_high = 5'(int'(b) - base);
              lit_over = (dec_count + size > capacity);
              ph = PhLiteral;
            end
          end else begin
            rv = b - s2erle_pkg::RunHdrBase;
            run_hi = rv[0];
            run_len = int'(rv[7:1]);
            ph = (run_len == int'(s2erle_pkg::RunExtCode)) ? PhRunExt : PhRunVal;
          end
        end
      end
      PhLiteral: begin
        val = b & s2erle_pkg::LowMask;
        if (lit_high[lit_idx]) begin
          val[7] = 1'b1;
        end
        r = '0;
        r.out_byte = val;
        r.repeat_count = 8'd1;
        decoded_q.push_back(r);
        lit_idx++;
        lit_left--;
        if (lit_left == 0) begin
          if (lit_over) begin
            err_st = s2erle_pkg::StLiteralOverflow;
            ph = PhDrop;
          end else begin
            dec_count += lit_idx;
            ph = PhHeader;
          end
        end else if (last) begin
          err_st = s2erle_pkg::StShortLiteral;
          ph = PhDrop;
        end
      end
      PhRunExt: begin
        if (last) begin
          err_st = s2erle_pkg::StShortRun;
          ph = PhDrop;
        end else begin
          run_len = int'(s2erle_pkg::RunExtCode) + int'(b & s2erle_pkg::LowMask);
          ph = PhRunVal;
        end
      end
      PhRunVal: begin
        if (dec_count + run_len > capacity) begin
          err_st = s2erle_pkg::StRunOverflow;
          ph = PhDrop;
        end else begin
          r = '0;
          r.out_byte = b + (run_hi ? 8'h80 : 8'h00);
          r.repeat_count = 8'(run_len);
          decoded_q.push_back(r);
          dec_count += run_len;
          ph = PhHeader;
        end
      end
      default: ;
    endcase
    if (last) begin
      r = '0;
      r.is_end = 1'b1;
      r.status = err_st;
      r.total_length = 11'(dec_count);
      decoded_q.push_back(r);
      clear_message();
    end
  endtask

  always @(posedge clk) begin : monitor_p
    s2erle_pkg::result_t want;
    logic                out_fire;
    if (!rst) begin
      in_fire = in_ch.valid && in_ch.ready;
      out_fire = out_ch.valid && out_ch.ready;
      if (in_fire) begin
        decode_byte(in_ch.in_byte, in_ch.is_last);
      end
      if (out_fire) begin
        if (decoded_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result: byte %02h count %0d end %0b status %0d",
                                    out_ch.out_byte, out_ch.repeat_count, out_ch.is_end,
                                    out_ch.status));
        end else begin
          want = decoded_q.pop_front();
          if (out_ch.out_byte !== want.out_byte) begin
            report_mismatch($sformatf("out_byte %02h, expected %02h",
                                      out_ch.out_byte, want.out_byte));
          end
          if (out_ch.repeat_count !== want.repeat_count) begin
            report_mismatch($sformatf("repeat_count %0d, expected %0d",
                                      out_ch.repeat_count, want.repeat_count));
          end
          if (out_ch.is_end !== want.is_end) begin
            report_mismatch($sformatf("is_end %0b, expected %0b", out_ch.is_end, want.is_end));
          end
          if (out_ch.status !== want.status) begin
            report_mismatch($sformatf("status %0d, expected %0d", out_ch.status, want.status));
          end
          if (out_ch.total_length !== want.total_length) begin
            report_mismatch($sformatf("total_length %0d, expected %0d",
                                      out_ch.total_length, want.total_length));
          end
        end
      end
      if (in_fire || out_fire) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  always @(negedge clk) begin : driver_p
    in_item_t nxt;
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_fire) begin
        drv_busy = 1'b0;
      end
      if (!drv_busy) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_q.size() != 0) begin
          nxt = pending_q.pop_front();
          in_ch.in_byte <= nxt.data;
          in_ch.is_last <= nxt.last;
          drv_busy = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? int'($urandom_range(20, 60))
                                                     : int'($urandom_range(0, 8));
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 6));
          end
        end
      end
      in_ch.valid <= drv_busy;
    end
  end

  always @(negedge clk) begin : receiver_p
    logic take;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_left = int'($urandom_range(16, 128));
      end
      rx_left--;
      rx_tick++;
      case (rx_mode)
        RxOpen: take = 1'b1;
        RxCoin: take = ($urandom_range(0, 1) == 1);
        RxSparse: take = ($urandom_range(0, 3) == 0);
        default: take = (rx_tick % 9) < 4;
      endcase
      out_ch.ready <= take;
    end
  end

  task automatic add_item(input logic [7:0] data, input logic last);
    pending_q.push_back(in_item_t'{data, last});
    queued_items++;
  endtask

  task automatic write_capacity(input logic [10:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    capacity = (int'(value) > CapMax) ? CapMax : int'(value);
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0 || drv_busy || decoded_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic gen_message(input bit closed);
    logic [7:0] body[$];
    int         mode;
    int         nblk;
    int         cls;
    int         h;
    int         cut;
    mode = int'($urandom_range(0, 19));
    if (mode == 0) begin
      repeat ($urandom_range(1, 8)) body.push_back(8'($urandom_range(0, 255)));
    end else begin
      nblk = ($urandom_range(0, 7) == 0) ? int'($urandom_range(6, 14))
                                         : int'($urandom_range(1, 4));
      repeat (nblk) begin
        if ($urandom_range(0, 1) == 1) begin
          cls = int'($urandom_range(0, 3));
          case (cls)
            0: h = int'($urandom_range(0, int'(s2erle_pkg::Lit3Start) - 1));
            1: h = int'($urandom_range(int'(s2erle_pkg::Lit3Start),
                                       int'(s2erle_pkg::Lit4Start) - 1));
            2: h = int'($urandom_range(int'(s2erle_pkg::Lit4Start),
                                       int'(s2erle_pkg::Lit5Start) - 1));
            default: h = int'($urandom_range(int'(s2erle_pkg::Lit5Start),
                                             int'(s2erle_pkg::BadHdrStart) - 1));
          endcase
          if ($urandom_range(0, 29) == 0) begin
            h = int'($urandom_range(int'(s2erle_pkg::BadHdrStart),
                                    int'(s2erle_pkg::RunHdrBase) - 1));
          end
          body.push_back(8'(h));
          repeat (cls + 2) body.push_back(8'($urandom_range(0, 255)));
        end else begin
          if ($urandom_range(0, 2) == 0) begin
            h = int'(s2erle_pkg::RunHdrBase) + 2 * int'(s2erle_pkg::RunExtCode)
                + int'($urandom_range(0, 1));
          end else begin
            h = int'($urandom_range(int'(s2erle_pkg::RunHdrBase), 255));
          end
          body.push_back(8'(h));
          if (((h - int'(s2erle_pkg::RunHdrBase)) >> 1) == int'(s2erle_pkg::RunExtCode)) begin
            body.push_back(8'($urandom_range(0, 255)));
          end
          body.push_back(8'($urandom_range(0, 255)));
        end
      end
      case ($urandom_range(0, 9))
        0: begin
          cut = int'($urandom_range(1, 3));
          while (cut > 0 && body.size() > 1) begin
            void'(body.pop_back());
            cut--;
          end
        end
        1: body.push_back(8'($urandom_range(0, 255)));
        default: ;
      endcase
    end
    foreach (body[i]) begin
      add_item(body[i], closed && (i == body.size() - 1));
    end
  endtask

  initial begin : stimulus_p
    int cap;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_ch.valid = 1'b0;
    in_ch.in_byte = '0;
    in_ch.is_last = 1'b0;
    out_ch.ready = 1'b0;
    capacity = CapMax;
    clear_message();
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    write_capacity(11'd2047);
    add_item(8'd3, 1'b0);
    add_item(8'hFF, 1'b0);
    add_item(8'h00, 1'b0);
    add_item(8'd59, 1'b0);
    add_item(8'h80, 1'b0);
    add_item(8'h7F, 1'b0);
    add_item(8'h55, 1'b0);
    add_item(8'h2A, 1'b0);
    add_item(8'h01, 1'b0);
    add_item(8'hFF, 1'b0);
    add_item(8'hFF, 1'b0);
    add_item(8'd126, 1'b0);
    add_item(8'hFF, 1'b0);
    add_item(8'h80, 1'b1);
    add_item(8'd60, 1'b0);
    add_item(8'hAA, 1'b1);
    add_item(8'd8, 1'b1);
    add_item(8'd4, 1'b0);
    add_item(8'h41, 1'b1);
    add_item(8'd127, 1'b0);
    add_item(8'h33, 1'b1);
    add_item(8'd66, 1'b0);
    wait_drained();

    // The run opened above gets its value byte after the capacity drops to zero, so it ends in a run overflow.
    write_capacity(11'd0);
    add_item(8'h5A, 1'b1);
    add_item(8'd1, 1'b0);
    add_item(8'h10, 1'b0);
    add_item(8'h20, 1'b1);
    add_item(8'd12, 1'b0);
    add_item(8'h7E, 1'b1);
    wait_drained();

    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: cap = 1024;
        1: cap = 2047;
        2: cap = 0;
        3: cap = 1;
        4: cap = int'($urandom_range(2, 60));
        5: cap = int'($urandom_range(100, 400));
        6: cap = int'($urandom_range(0, 2047));
        default: cap = 1024;
      endcase
      write_capacity(11'(cap));
      queued_items = 0;
      while (queued_items < PhaseItems) begin
        gen_message(1'b1);
      end
      if ($urandom_range(0, 2) == 0) begin
        gen_message(1'b0);
      end
      wait_drained();
    end

    if (decoded_q.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", decoded_q.size()));
    end
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
